// ===== src/dgp_pkg.sv =====
// shared widths, constants and types of the dryden gust psd datapath
package dgp_pkg;

   // input and output field widths
   localparam int SIGMA_W = 16;
   localparam int LEN_W   = 12;
   localparam int FREQ_W  = 16;
   localparam int PSD_W   = 48;

   // default number of fraction bits in the result
   localparam int OUT_FRAC_BITS_DEF = 16;

   // intermediate widths
   localparam int LW_W   = LEN_W + FREQ_W;        // L*w
   localparam int SQ_W   = 2 * SIGMA_W;           // sigma^2
   localparam int P_W    = 2 * LW_W;              // (L*w)^2, Q32
   localparam int T_W    = SQ_W + LEN_W + 1;      // sigma^2 * 2L
   localparam int INVPI_W = 31;
   localparam int T_SPLIT = 23;                   // low slice of T for the 1/pi product
   localparam int PL_W   = T_SPLIT + INVPI_W;
   localparam int PH_W   = (T_W - T_SPLIT) + INVPI_W;
   localparam int PROD_W = T_W + INVPI_W;         // T * 1/pi before the Q16 shift
   localparam int T0_W   = PROD_W - 16;           // sigma^2*2L/pi in Q32
   localparam int DEN_W  = 58;                    // 2^32 + p or 2^32 + 4p
   localparam int M1_W   = 60;                    // 2^32 + 12p or 2^32 + p
   localparam int HALF_W = 30;                    // partial product slice
   localparam int PP_W   = 2 * HALF_W;
   localparam int MID_W  = PP_W + 1;
   localparam int N1_W   = T0_W + M1_W;           // numerator of the first divide
   localparam int A_W    = 62;                    // first quotient, below 3 * 2^60

   // restoring divide retires this many quotient bits per stage
   localparam int DIV_STEP = 2;

   // register stages of the front end (multiplies and adds)
   localparam int FRONT_STAGES = 7;

   // accept-to-strobe latency in clock cycles
   localparam int LATENCY = FRONT_STAGES + (A_W / DIV_STEP) + (PSD_W / DIV_STEP) + 3;

   // floor(2^32 / pi)
   localparam logic [INVPI_W-1:0] INVPI_Q32 = 31'h517C_C1B7;

   localparam logic [DEN_W-1:0] ONE_DEN = DEN_W'(64'h1_0000_0000);
   localparam logic [M1_W-1:0]  ONE_M1  = M1_W'(64'h1_0000_0000);

   typedef enum logic {
      AXIS_LONG    = 1'b0,
      AXIS_LATVERT = 1'b1
   } axis_type;

endpackage

// ===== src/dgp_front.sv =====
// front end: products, denominator and first divide numerator over seven stages
module dgp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_action,
   input  logic [dgp_pkg::SIGMA_W-1:0] in_sigma,
   input  logic [dgp_pkg::LEN_W-1:0]   in_len,
   input  logic [dgp_pkg::FREQ_W-1:0]  in_freq,
   output logic                        out_valid,
   output logic [dgp_pkg::N1_W-1:0]    out_num,
   output logic [dgp_pkg::DEN_W-1:0]   out_den
);
   import dgp_pkg::*;

   logic [FRONT_STAGES-1:0] valid_ff;

   // stage 1
   axis_type           act1_ff;
   logic [LEN_W-1:0]   len1_ff;
   logic [LW_W-1:0]    lw_ff, lw_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   // stage 2
   axis_type           act2_ff;
   logic [P_W-1:0]     p_ff, p_in;
   logic [T_W-1:0]     t_ff, t_in;
   // stage 3
   logic [PL_W-1:0]    pl_ff, pl_in;
   logic [PH_W-1:0]    ph_ff, ph_in;
   logic [DEN_W-1:0]   den3_ff, den3_in;
   logic [M1_W-1:0]    m13_ff, m13_in;
   // stage 4
   logic [PROD_W-1:0]  prod_in;
   logic [T0_W-1:0]    t0_ff;
   logic [DEN_W-1:0]   den4_ff;
   logic [M1_W-1:0]    m14_ff;
   // stage 5
   logic [PP_W-1:0]    ll_ff, lh_ff, hl_ff, hh_ff;
   logic [PP_W-1:0]    ll_in, lh_in, hl_in, hh_in;
   logic [DEN_W-1:0]   den5_ff;
   // stage 6
   logic [MID_W-1:0]   mid_ff, mid_in;
   logic [N1_W-1:0]    cat_ff;
   logic [DEN_W-1:0]   den6_ff;
   // stage 7
   logic [N1_W-1:0]    n1_ff, n1_in;
   logic [DEN_W-1:0]   den7_ff;

   always_comb begin
      lw_in   = LW_W'(in_len) * LW_W'(in_freq);
      sq_in   = SQ_W'(in_sigma) * SQ_W'(in_sigma);

      p_in    = P_W'(lw_ff) * P_W'(lw_ff);
      t_in    = T_W'(sq_ff) * T_W'({len1_ff, 1'b0});

      pl_in   = PL_W'(t_ff[T_SPLIT-1:0]) * PL_W'(INVPI_Q32);
      ph_in   = PH_W'(t_ff[T_W-1:T_SPLIT]) * PH_W'(INVPI_Q32);
      if (act2_ff == AXIS_LATVERT) begin
         den3_in = ONE_DEN + DEN_W'({p_ff, 2'b00});
         m13_in  = ONE_M1 + M1_W'({p_ff, 3'b000}) + M1_W'({p_ff, 2'b00});
      end else begin
         den3_in = ONE_DEN + DEN_W'(p_ff);
         m13_in  = ONE_M1 + M1_W'(p_ff);
      end

      prod_in = {ph_ff, {T_SPLIT{1'b0}}} + PROD_W'(pl_ff);

      ll_in   = PP_W'(t0_ff[HALF_W-1:0])      * PP_W'(m14_ff[HALF_W-1:0]);
      lh_in   = PP_W'(t0_ff[HALF_W-1:0])      * PP_W'(m14_ff[M1_W-1:HALF_W]);
      hl_in   = PP_W'(t0_ff[T0_W-1:HALF_W])   * PP_W'(m14_ff[HALF_W-1:0]);
      hh_in   = PP_W'(t0_ff[T0_W-1:HALF_W])   * PP_W'(m14_ff[M1_W-1:HALF_W]);

      mid_in  = MID_W'(lh_ff) + MID_W'(hl_ff);

      n1_in   = cat_ff + N1_W'({mid_ff, {HALF_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      act1_ff <= axis_type'(in_action);
      len1_ff <= in_len;
      lw_ff   <= lw_in;
      sq_ff   <= sq_in;

      act2_ff <= act1_ff;
      p_ff    <= p_in;
      t_ff    <= t_in;

      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
      den3_ff <= den3_in;
      m13_ff  <= m13_in;

      t0_ff   <= prod_in[PROD_W-1:16];
      den4_ff <= den3_ff;
      m14_ff  <= m13_ff;

      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      den5_ff <= den4_ff;

      mid_ff  <= mid_in;
      cat_ff  <= {hh_ff, ll_ff};
      den6_ff <= den5_ff;

      n1_ff   <= n1_in;
      den7_ff <= den6_ff;
   end

   assign out_valid = valid_ff[FRONT_STAGES-1];
   assign out_num   = n1_ff;
   assign out_den   = den7_ff;

endmodule

// ===== src/dgp_div_pipe.sv =====
// pipelined restoring divider, dgp_pkg::DIV_STEP quotient bits per stage, flagging overflow
module dgp_div_pipe #(
   parameter int NUM_W = dgp_pkg::N1_W,
   parameter int DEN_W = dgp_pkg::DEN_W,
   parameter int Q_W   = dgp_pkg::A_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic             out_ovf,
   output logic [Q_W-1:0]   out_quo,
   output logic [DEN_W-1:0] out_den
);
   import dgp_pkg::*;

   localparam int HI_W   = NUM_W - Q_W;
   localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int NSTAGE = Q_W / DIV_STEP;

   logic [NSTAGE:0]  valid_ff;
   logic [DEN_W-1:0] rem_ff [NSTAGE+1];
   logic [DEN_W-1:0] rem_in [NSTAGE+1];
   logic [Q_W-1:0]   ql_ff  [NSTAGE+1];   // numerator bits shift out on top, quotient in below
   logic [Q_W-1:0]   ql_in  [NSTAGE+1];
   logic [DEN_W-1:0] den_ff [NSTAGE+1];
   logic [DEN_W-1:0] den_in [NSTAGE+1];
   logic             ovf_ff [NSTAGE+1];
   logic             ovf_in [NSTAGE+1];

   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;
   logic [DEN_W-1:0] step_rem;
   logic [Q_W-1:0]   step_ql;
   logic [DEN_W:0]   step_sh;

   always_comb begin
      // entry: a high part at or above the divisor means the quotient does not fit
      hi_ext    = CMP_W'(in_num[NUM_W-1:Q_W]);
      den_ext   = CMP_W'(in_den);
      ovf_in[0] = (hi_ext >= den_ext);
      rem_in[0] = ovf_in[0] ? '0 : hi_ext[DEN_W-1:0];
      ql_in[0]  = in_num[Q_W-1:0];
      den_in[0] = in_den;

      step_rem = '0;
      step_ql  = '0;
      step_sh  = '0;
      for (int s = 0; s < NSTAGE; s++) begin
         step_rem = rem_ff[s];
         step_ql  = ql_ff[s];
         for (int k = 0; k < DIV_STEP; k++) begin
            step_sh = {step_rem, step_ql[Q_W-1]};
            step_ql = {step_ql[Q_W-2:0], 1'b0};
            if (step_sh >= {1'b0, den_ff[s]}) begin
               step_sh    = step_sh - {1'b0, den_ff[s]};
               step_ql[0] = 1'b1;
            end
            step_rem = step_sh[DEN_W-1:0];
         end
         rem_in[s+1] = step_rem;
         ql_in[s+1]  = step_ql;
         den_in[s+1] = den_ff[s];
         ovf_in[s+1] = ovf_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NSTAGE-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= NSTAGE; s++) begin
         rem_ff[s] <= rem_in[s];
         ql_ff[s]  <= ql_in[s];
         den_ff[s] <= den_in[s];
         ovf_ff[s] <= ovf_in[s];
      end
   end

   assign out_valid = valid_ff[NSTAGE];
   assign out_ovf   = ovf_ff[NSTAGE];
   assign out_quo   = ql_ff[NSTAGE];
   assign out_den   = den_ff[NSTAGE];

endmodule

// ===== src/dryden_gust_psd_core.sv =====
// top level of the dryden gust psd evaluator
// One frequency point per transfer: start with busy low takes an item every
// clock, and busy never rises, so a full sweep streams without gaps. Each
// result appears on rsp_psd / rsp_saturated for exactly one cycle with
// rsp_strobe high, in the same order the items went in. The receiver cannot
// hold results off, so it must take every strobe. The pipeline is made of the
// two pipelined restoring dividers, which retire two quotient bits per stage
// (31 stages for the lateral ratio, 24 for the final scaling, one entry stage
// each), behind seven stages of multiplies and adds and one output register.
module dryden_gust_psd_core #(
   parameter int OUT_FRAC_BITS = dgp_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [dgp_pkg::SIGMA_W-1:0] req_sigma,
   input  logic [dgp_pkg::LEN_W-1:0]   req_scale_length,
   input  logic [dgp_pkg::FREQ_W-1:0]  req_spatial_freq,
   output logic                        rsp_strobe,
   output logic [dgp_pkg::PSD_W-1:0]   rsp_psd,
   output logic                        rsp_saturated
);
   import dgp_pkg::*;

   // second divide numerator: first quotient scaled by 2^OUT_FRAC_BITS
   localparam int N2_W = A_W + OUT_FRAC_BITS;

   logic              accept;
   logic              fe_valid;
   logic [N1_W-1:0]   fe_num;
   logic [DEN_W-1:0]  fe_den;
   logic              d1_valid;
   logic [A_W-1:0]    d1_quo;
   logic [DEN_W-1:0]  d1_den;
   logic              d2_valid;
   logic              d2_ovf;
   logic [PSD_W-1:0]  d2_quo;

   logic              strobe_ff;
   logic [PSD_W-1:0]  psd_ff;
   logic              sat_ff;

   // fully pipelined, never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // front end: x^2, sigma^2*2L/pi in Q32, the divisor and t0 * numerator factor.
   // longitudinal uses the divisor itself as the factor so the first divide returns t0
   dgp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_action (req_action),
      .in_sigma  (req_sigma),
      .in_len    (req_scale_length),
      .in_freq   (req_spatial_freq),
      .out_valid (fe_valid),
      .out_num   (fe_num),
      .out_den   (fe_den)
   );

   // lateral ratio (1 + 12x^2)/(1 + 4x^2) applied to t0; the quotient stays
   // below 3 * 2^60, so its overflow flag never rises
   dgp_div_pipe #(
      .NUM_W (N1_W),
      .DEN_W (DEN_W),
      .Q_W   (A_W)
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_num    (fe_num),
      .in_den    (fe_den),
      .out_valid (d1_valid),
      .out_ovf   (),
      .out_quo   (d1_quo),
      .out_den   (d1_den)
   );

   // final divide into the output format, overflow flags saturation
   dgp_div_pipe #(
      .NUM_W (N2_W),
      .DEN_W (DEN_W),
      .Q_W   (PSD_W)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_num    ({d1_quo, {OUT_FRAC_BITS{1'b0}}}),
      .in_den    (d1_den),
      .out_valid (d2_valid),
      .out_ovf   (d2_ovf),
      .out_quo   (d2_quo),
      .out_den   ()
   );

   // output register, one strobe per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      psd_ff <= d2_ovf ? {PSD_W{1'b1}} : d2_quo;
      sat_ff <= d2_ovf;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_psd       = psd_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== src/dgp_checker.sv =====
// port-level checks of the dryden gust psd core, bound to the top level
module dgp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_action,
   input logic [dgp_pkg::SIGMA_W-1:0] req_sigma,
   input logic [dgp_pkg::LEN_W-1:0]   req_scale_length,
   input logic [dgp_pkg::FREQ_W-1:0]  req_spatial_freq,
   input logic                        rsp_strobe,
   input logic [dgp_pkg::PSD_W-1:0]   rsp_psd,
   input logic                        rsp_saturated
);
   import dgp_pkg::*;

   // every accepted transfer gives a result after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result strobe");

   // no result without an accepted item at the matching edge
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, LATENCY))
      else $error("result strobe without a matching accepted item");

   // zero intensity or zero scale length gives a zero result
   a_zero_input: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_sigma == '0 || req_scale_length == '0))
      |-> ##LATENCY (rsp_psd == '0 && !rsp_saturated))
      else $error("zero sigma or length gave a nonzero result");

   // a saturated result reads full scale
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |-> (rsp_psd == {PSD_W{1'b1}}))
      else $error("saturated result not at full scale");

endmodule

bind dryden_gust_psd_core dgp_checker u_dgp_checker (.*);
